FILE: hw/rtl/nq_pkg.sv
// ----------------------------------------------------------------------------
// nq_pkg
// Shared types and constants of the N-queens solution enumerator.
// ----------------------------------------------------------------------------
package nq_pkg;

  localparam int MAX_SIZE_DEF = 16;   // default board limit
  localparam int COL_W        = 4;    // bits of one queen column
  localparam int ROW_W        = 4;    // bits of a row index (16 rows max)
  localparam int SIZE_W       = 5;    // board size register width
  localparam int CNT_W        = 32;   // solution counter width
  localparam int COLS_W       = 64;   // packed column word width

  localparam logic [SIZE_W-1:0] BOARD_SIZE_RESET = 5'd8;

  localparam logic CMD_RESTART = 1'b0;
  localparam logic CMD_NEXT    = 1'b1;

  typedef struct packed {
    logic              command;
    logic [SIZE_W-1:0] prefix_rows;
    logic [COLS_W-1:0] prefix_columns;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [CNT_W-1:0]  solution_number;
    logic [COLS_W-1:0] solution_columns;
    logic              bad_request;
  } out_item_t;

  // one access to the column stack: an optional write and a read address
  typedef struct packed {
    logic             we;
    logic [ROW_W-1:0] waddr;
    logic [COL_W-1:0] wdata;
    logic [ROW_W-1:0] raddr;
  } stk_req_t;

endpackage

FILE: hw/rtl/n_queens_solution_enumerator_unit.sv
// ----------------------------------------------------------------------------
// n_queens_solution_enumerator_unit
// N-queens enumerator: depth-first search over a column stack in memory.
// ----------------------------------------------------------------------------
// One request is handled at a time. A restart writes every stack row, one
// stack write per row. A next request searches on from the stored stack:
// every candidate square in row r is checked against the earlier rows, which
// are read from the single stack read port one per cycle; a backtrack step
// rereads the row above, and a found solution's columns are then read out row
// by row. The result is held in an output register, so a new request is taken
// while the previous result waits. Configuration writes are always ready and
// take effect at once, also on a request in progress.
module n_queens_solution_enumerator_unit
  import nq_pkg::*;
#(
  parameter int MAX_SIZE = MAX_SIZE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] cfg_data
);

  logic [SIZE_W-1:0] board_size_r;
  logic [SIZE_W-1:0] n_eff;
  logic              out_valid_r;
  out_item_t         out_data_r;
  logic              res_valid;
  logic              res_ready;
  out_item_t         res_item;
  stk_req_t          req;
  logic [COL_W-1:0]  rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      board_size_r <= BOARD_SIZE_RESET;
    end else if (cfg_valid) begin
      board_size_r <= cfg_data;
    end
  end

  // 0 behaves as 1, oversize as MAX_SIZE
  always_comb begin
    if (board_size_r == '0) begin
      n_eff = SIZE_W'(1);
    end else if (board_size_r > SIZE_W'(MAX_SIZE)) begin
      n_eff = SIZE_W'(MAX_SIZE);
    end else begin
      n_eff = board_size_r;
    end
  end

  nq_stack_mem #(
    .MAX_SIZE (MAX_SIZE)
  ) u_stack (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  nq_search_ctrl #(
    .MAX_SIZE (MAX_SIZE)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .n         (n_eff),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item),
    .req       (req),
    .rd_data   (rd_data)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hw/rtl/nq_stack_mem.sv
// ----------------------------------------------------------------------------
// nq_stack_mem
// Column stack: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module nq_stack_mem
  import nq_pkg::*;
#(
  parameter int MAX_SIZE = MAX_SIZE_DEF
) (
  input  logic             clk,
  input  stk_req_t         req,
  output logic [COL_W-1:0] rd_data
);

  localparam int AW = $clog2(MAX_SIZE);

  logic [COL_W-1:0] mem [MAX_SIZE];
  logic [COL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
    rd_data_r <= mem[req.raddr[AW-1:0]];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/nq_search_ctrl.sv
// ----------------------------------------------------------------------------
// nq_search_ctrl
// Backtracking sequencer: walks the column stack through the memory port,
// one stored row per cycle for conflict checks and result gathering.
// ----------------------------------------------------------------------------
module nq_search_ctrl
  import nq_pkg::*;
#(
  parameter int MAX_SIZE = MAX_SIZE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [SIZE_W-1:0] n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_item,
  output logic              res_valid,
  input  logic              res_ready,
  output out_item_t         res_item,
  output stk_req_t          req,
  input  logic [COL_W-1:0]  rd_data
);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_CLR  = 10'b00_0000_0010,
    ST_CUR  = 10'b00_0000_0100,
    ST_EVAL = 10'b00_0000_1000,
    ST_CHK  = 10'b00_0001_0000,
    ST_FREE = 10'b00_0010_0000,
    ST_STEP = 10'b00_0100_0000,
    ST_BTW  = 10'b00_1000_0000,
    ST_GATH = 10'b01_0000_0000,
    ST_OUT  = 10'b10_0000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic [ROW_W-1:0]  cur_r, cur_nxt;
  logic [ROW_W-1:0]  fix_r, fix_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              exh_r, exh_nxt;
  logic              sol_r, sol_nxt;
  logic              bad_r, bad_nxt;
  logic [COL_W-1:0]  c_r, c_nxt;
  logic [ROW_W-1:0]  j_r, j_nxt;
  logic [COLS_W-1:0] pfx_r, pfx_nxt;
  logic [COLS_W-1:0] cols_r, cols_nxt;

  logic [ROW_W-1:0]  dr;
  logic [COL_W-1:0]  dc;
  logic              conflict;

  // diagonal / column test of stored row j_r against candidate c_r
  always_comb begin
    dr       = cur_r - j_r;
    dc       = (rd_data > c_r) ? (rd_data - c_r) : (c_r - rd_data);
    conflict = (rd_data == c_r) || (COL_W'(dr) == dc);
  end

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    fix_nxt   = fix_r;
    cnt_nxt   = cnt_r;
    exh_nxt   = exh_r;
    sol_nxt   = sol_r;
    bad_nxt   = bad_r;
    c_nxt     = c_r;
    j_nxt     = j_r;
    pfx_nxt   = pfx_r;
    cols_nxt  = cols_r;
    req       = '0;
    in_ready  = 1'b0;
    res_valid = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          sol_nxt  = 1'b0;
          bad_nxt  = 1'b0;
          cols_nxt = '0;
          if (in_item.command == CMD_RESTART) begin
            cnt_nxt = '0;
            pfx_nxt = in_item.prefix_columns;
            j_nxt   = '0;
            if (in_item.prefix_rows >= n) begin
              bad_nxt = 1'b1;
              fix_nxt = '0;
              cur_nxt = '0;
              exh_nxt = 1'b1;
            end else begin
              fix_nxt = ROW_W'(in_item.prefix_rows);
              cur_nxt = ROW_W'(in_item.prefix_rows);
              exh_nxt = 1'b0;
            end
            state_nxt = ST_CLR;
          end else if (exh_r || (SIZE_W'(cur_r) >= n) || (SIZE_W'(fix_r) >= n)) begin
            exh_nxt   = 1'b1;
            state_nxt = ST_OUT;
          end else begin
            req.raddr = cur_r;
            state_nxt = ST_CUR;
          end
        end
      end

      // load prefix, zero the rest of the stack
      ST_CLR: begin
        req.we    = 1'b1;
        req.waddr = j_r;
        req.wdata = (j_r < fix_r) ? pfx_r[COL_W*j_r +: COL_W] : '0;
        if (j_r == ROW_W'(MAX_SIZE - 1)) begin
          state_nxt = ST_OUT;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end

      ST_CUR: begin
        c_nxt     = rd_data;
        state_nxt = ST_EVAL;
      end

      ST_EVAL: begin
        if (SIZE_W'(c_r) >= n) begin
          state_nxt = ST_STEP;
        end else if (cur_r == '0) begin
          state_nxt = ST_FREE;
        end else begin
          req.raddr = '0;
          j_nxt     = '0;
          state_nxt = ST_CHK;
        end
      end

      // rd_data holds row j_r; the next row is requested in this state
      ST_CHK: begin
        if (conflict) begin
          state_nxt = ST_STEP;
        end else if (j_r + 1'b1 == cur_r) begin
          state_nxt = ST_FREE;
        end else begin
          j_nxt     = j_r + 1'b1;
          req.raddr = j_r + 1'b1;
        end
      end

      ST_FREE: begin
        if (SIZE_W'(cur_r) + 1'b1 == n) begin
          if (cnt_r != '1) begin
            cnt_nxt = cnt_r + 1'b1;
          end
          sol_nxt   = 1'b1;
          req.raddr = '0;
          j_nxt     = '0;
          state_nxt = ST_GATH;
        end else begin
          // descend one row, first candidate column 0
          cur_nxt   = cur_r + 1'b1;
          req.we    = 1'b1;
          req.waddr = cur_r + 1'b1;
          req.wdata = '0;
          c_nxt     = '0;
          req.raddr = '0;
          j_nxt     = '0;
          state_nxt = ST_CHK;
        end
      end

      ST_GATH: begin
        cols_nxt[COL_W*j_r +: COL_W] = rd_data;
        if (SIZE_W'(j_r) + 1'b1 == n) begin
          state_nxt = ST_STEP;
        end else begin
          j_nxt     = j_r + 1'b1;
          req.raddr = j_r + 1'b1;
        end
      end

      // advance candidate of row cur_r, backtracking as needed; end the search when the prefix row is exhausted
      ST_STEP: begin
        if (SIZE_W'(c_r) + 1'b1 < n) begin
          req.we    = 1'b1;
          req.waddr = cur_r;
          req.wdata = c_r + 1'b1;
          c_nxt     = c_r + 1'b1;
          state_nxt = sol_r ? ST_OUT : ST_EVAL;
        end else if (cur_r <= fix_r) begin
          exh_nxt   = 1'b1;
          state_nxt = ST_OUT;
        end else begin
          cur_nxt   = cur_r - 1'b1;
          req.raddr = cur_r - 1'b1;
          state_nxt = ST_BTW;
        end
      end

      ST_BTW: begin
        c_nxt     = rd_data;
        state_nxt = ST_STEP;
      end

      ST_OUT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_item.found            = sol_r;
    res_item.solution_number  = cnt_r;
    res_item.solution_columns = cols_r;
    res_item.bad_request      = bad_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cur_r   <= '0;
      fix_r   <= '0;
      cnt_r   <= '0;
      exh_r   <= 1'b1;
      sol_r   <= 1'b0;
      bad_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      fix_r   <= fix_nxt;
      cnt_r   <= cnt_nxt;
      exh_r   <= exh_nxt;
      sol_r   <= sol_nxt;
      bad_r   <= bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r    <= c_nxt;
    j_r    <= j_nxt;
    pfx_r  <= pfx_nxt;
    cols_r <= cols_nxt;
  end

endmodule
